[rtl/ltn_pkg.sv]
// shared types, constants and the micro-op program of the undistort sequencer
// depends on nothing; used by ltn_mul, ltn_div and lens_undistort_newton
`timescale 1ns / 1ps

package ltn_pkg;

    localparam int COORD_FRAC_DEFAULT = 24;
    localparam int COEF_FRAC_DEFAULT  = 56;
    localparam logic [7:0] STEP_LIMIT_RESET = 8'd20;

    // configuration register indexes
    localparam logic [2:0] CFG_CENTER    = 3'd0;
    localparam logic [2:0] CFG_KAPPA1    = 3'd1;
    localparam logic [2:0] CFG_KAPPA2    = 3'd2;
    localparam logic [2:0] CFG_KAPPA3    = 3'd3;
    localparam logic [2:0] CFG_RHO1      = 3'd4;
    localparam logic [2:0] CFG_RHO2      = 3'd5;
    localparam logic [2:0] CFG_ERR_LIMIT = 3'd6;
    localparam logic [2:0] CFG_STEP_LIM  = 3'd7;

    // status codes
    localparam logic [1:0] ST_CONVERGED = 2'd0;
    localparam logic [1:0] ST_LIMIT     = 2'd1;
    localparam logic [1:0] ST_SINGULAR  = 2'd2;

    typedef enum logic [3:0] {
        OP_ADD, OP_SUB, OP_MUL0, OP_MULI, OP_MULC, OP_DIV, OP_BERR, OP_BDET, OP_NEXT
    } t_opk;

    typedef enum logic [1:0] {
        SH_NONE, SH_COORD, SH_COEF
    } t_shsel;

    typedef struct packed {
        t_opk        kind;
        logic [4:0]  dst;
        logic [5:0]  src_a;
        logic [5:0]  src_b;
    } t_uop;

    // register file addresses
    localparam logic [4:0] R_PX   = 5'd0;
    localparam logic [4:0] R_PY   = 5'd1;
    localparam logic [4:0] R_P1X2 = 5'd2;
    localparam logic [4:0] R_P2X2 = 5'd3;
    localparam logic [4:0] R_P1X6 = 5'd4;
    localparam logic [4:0] R_P2X6 = 5'd5;
    localparam logic [4:0] R_K1X2 = 5'd6;
    localparam logic [4:0] R_K2X4 = 5'd7;
    localparam logic [4:0] R_K3X6 = 5'd8;
    localparam logic [4:0] R_DX   = 5'd9;
    localparam logic [4:0] R_DY   = 5'd10;
    localparam logic [4:0] R_DXX  = 5'd11;
    localparam logic [4:0] R_DYY  = 5'd12;
    localparam logic [4:0] R_DXY  = 5'd13;
    localparam logic [4:0] R_R2   = 5'd14;
    localparam logic [4:0] R_T0   = 5'd15;
    localparam logic [4:0] R_DV   = 5'd16;
    localparam logic [4:0] R_FX   = 5'd17;
    localparam logic [4:0] R_FY   = 5'd18;
    localparam logic [4:0] R_T1   = 5'd19;
    localparam logic [4:0] R_ERR  = 5'd20;
    localparam logic [4:0] R_G    = 5'd21;
    localparam logic [4:0] R_JA   = 5'd22;
    localparam logic [4:0] R_JB   = 5'd23;
    localparam logic [4:0] R_JD   = 5'd24;
    localparam logic [4:0] R_DET  = 5'd25;
    localparam logic [4:0] R_NX   = 5'd26;
    localparam logic [4:0] R_NY   = 5'd27;

    // operand addresses: bit 5 clear selects the register file
    localparam logic [5:0] A_PX   = {1'b0, R_PX};
    localparam logic [5:0] A_PY   = {1'b0, R_PY};
    localparam logic [5:0] A_P1X2 = {1'b0, R_P1X2};
    localparam logic [5:0] A_P2X2 = {1'b0, R_P2X2};
    localparam logic [5:0] A_P1X6 = {1'b0, R_P1X6};
    localparam logic [5:0] A_P2X6 = {1'b0, R_P2X6};
    localparam logic [5:0] A_K1X2 = {1'b0, R_K1X2};
    localparam logic [5:0] A_K2X4 = {1'b0, R_K2X4};
    localparam logic [5:0] A_K3X6 = {1'b0, R_K3X6};
    localparam logic [5:0] A_DX   = {1'b0, R_DX};
    localparam logic [5:0] A_DY   = {1'b0, R_DY};
    localparam logic [5:0] A_DXX  = {1'b0, R_DXX};
    localparam logic [5:0] A_DYY  = {1'b0, R_DYY};
    localparam logic [5:0] A_DXY  = {1'b0, R_DXY};
    localparam logic [5:0] A_R2   = {1'b0, R_R2};
    localparam logic [5:0] A_T0   = {1'b0, R_T0};
    localparam logic [5:0] A_DV   = {1'b0, R_DV};
    localparam logic [5:0] A_FX   = {1'b0, R_FX};
    localparam logic [5:0] A_FY   = {1'b0, R_FY};
    localparam logic [5:0] A_T1   = {1'b0, R_T1};
    localparam logic [5:0] A_ERR  = {1'b0, R_ERR};
    localparam logic [5:0] A_G    = {1'b0, R_G};
    localparam logic [5:0] A_JA   = {1'b0, R_JA};
    localparam logic [5:0] A_JB   = {1'b0, R_JB};
    localparam logic [5:0] A_JD   = {1'b0, R_JD};
    localparam logic [5:0] A_DET  = {1'b0, R_DET};
    localparam logic [5:0] A_NX   = {1'b0, R_NX};
    localparam logic [5:0] A_NY   = {1'b0, R_NY};
    // specials: configuration, input point and constants
    localparam logic [5:0] S_ZERO = 6'd32;
    localparam logic [5:0] S_CX   = 6'd33;
    localparam logic [5:0] S_CY   = 6'd34;
    localparam logic [5:0] S_K1   = 6'd35;
    localparam logic [5:0] S_K2   = 6'd36;
    localparam logic [5:0] S_K3   = 6'd37;
    localparam logic [5:0] S_P1   = 6'd38;
    localparam logic [5:0] S_P2   = 6'd39;
    localparam logic [5:0] S_ONE  = 6'd40;
    localparam logic [5:0] S_C2   = 6'd41;
    localparam logic [5:0] S_C4   = 6'd42;
    localparam logic [5:0] S_C6   = 6'd43;
    localparam logic [5:0] S_XD   = 6'd44;
    localparam logic [5:0] S_YD   = 6'd45;

    localparam int PC_W = 7;
    localparam logic [PC_W-1:0] LOOP_PC = 7'd9;

    function automatic t_uop mk(input t_opk k, input logic [4:0] d,
                                input logic [5:0] a, input logic [5:0] b);
        t_uop u;
        u.kind  = k;
        u.dst   = d;
        u.src_a = a;
        u.src_b = b;
        return u;
    endfunction

    function automatic t_uop uop_rom(input logic [PC_W-1:0] pc);
        t_uop u;
        unique case (pc)
            7'd0:  u = mk(OP_ADD,  R_PX,   S_XD,   S_ZERO);
            7'd1:  u = mk(OP_ADD,  R_PY,   S_YD,   S_ZERO);
            7'd2:  u = mk(OP_MUL0, R_P1X2, S_P1,   S_C2);
            7'd3:  u = mk(OP_MUL0, R_P2X2, S_P2,   S_C2);
            7'd4:  u = mk(OP_MUL0, R_P1X6, S_P1,   S_C6);
            7'd5:  u = mk(OP_MUL0, R_P2X6, S_P2,   S_C6);
            7'd6:  u = mk(OP_MUL0, R_K1X2, S_K1,   S_C2);
            7'd7:  u = mk(OP_MUL0, R_K2X4, S_K2,   S_C4);
            7'd8:  u = mk(OP_MUL0, R_K3X6, S_K3,   S_C6);
            // newton step
            7'd9:  u = mk(OP_SUB,  R_DX,   A_PX,   S_CX);
            7'd10: u = mk(OP_SUB,  R_DY,   A_PY,   S_CY);
            7'd11: u = mk(OP_MULI, R_DXX,  A_DX,   A_DX);
            7'd12: u = mk(OP_MULI, R_DYY,  A_DY,   A_DY);
            7'd13: u = mk(OP_MULI, R_DXY,  A_DX,   A_DY);
            7'd14: u = mk(OP_ADD,  R_R2,   A_DXX,  A_DYY);
            7'd15: u = mk(OP_MULI, R_T0,   S_K3,   A_R2);
            7'd16: u = mk(OP_ADD,  R_T0,   S_K2,   A_T0);
            7'd17: u = mk(OP_MULI, R_T0,   A_T0,   A_R2);
            7'd18: u = mk(OP_ADD,  R_T0,   S_K1,   A_T0);
            7'd19: u = mk(OP_MULC, R_T0,   A_T0,   A_R2);
            7'd20: u = mk(OP_ADD,  R_DV,   S_ONE,  A_T0);
            7'd21: u = mk(OP_MULI, R_T0,   A_DX,   A_DV);
            7'd22: u = mk(OP_ADD,  R_FX,   S_CX,   A_T0);
            7'd23: u = mk(OP_MULC, R_T0,   A_P1X2, A_DXY);
            7'd24: u = mk(OP_ADD,  R_FX,   A_FX,   A_T0);
            7'd25: u = mk(OP_MUL0, R_T0,   A_DXX,  S_C2);
            7'd26: u = mk(OP_ADD,  R_T0,   A_R2,   A_T0);
            7'd27: u = mk(OP_MULC, R_T0,   S_P2,   A_T0);
            7'd28: u = mk(OP_ADD,  R_FX,   A_FX,   A_T0);
            7'd29: u = mk(OP_SUB,  R_FX,   A_FX,   S_XD);
            7'd30: u = mk(OP_MULI, R_T0,   A_DY,   A_DV);
            7'd31: u = mk(OP_ADD,  R_FY,   S_CY,   A_T0);
            7'd32: u = mk(OP_MUL0, R_T0,   A_DYY,  S_C2);
            7'd33: u = mk(OP_ADD,  R_T0,   A_R2,   A_T0);
            7'd34: u = mk(OP_MULC, R_T0,   S_P1,   A_T0);
            7'd35: u = mk(OP_ADD,  R_FY,   A_FY,   A_T0);
            7'd36: u = mk(OP_MULC, R_T0,   A_P2X2, A_DXY);
            7'd37: u = mk(OP_ADD,  R_FY,   A_FY,   A_T0);
            7'd38: u = mk(OP_SUB,  R_FY,   A_FY,   S_YD);
            7'd39: u = mk(OP_MULI, R_T0,   A_FX,   A_FX);
            7'd40: u = mk(OP_MULI, R_T1,   A_FY,   A_FY);
            7'd41: u = mk(OP_ADD,  R_ERR,  A_T0,   A_T1);
            7'd42: u = mk(OP_BERR, R_ERR,  A_ERR,  S_ZERO);
            7'd43: u = mk(OP_MULI, R_T0,   A_K3X6, A_R2);
            7'd44: u = mk(OP_ADD,  R_G,    A_K2X4, A_T0);
            7'd45: u = mk(OP_MULI, R_T0,   A_G,    A_R2);
            7'd46: u = mk(OP_ADD,  R_G,    A_K1X2, A_T0);
            7'd47: u = mk(OP_MULC, R_T0,   A_G,    A_DXX);
            7'd48: u = mk(OP_ADD,  R_JA,   A_DV,   A_T0);
            7'd49: u = mk(OP_MULC, R_T0,   A_P1X2, A_DY);
            7'd50: u = mk(OP_ADD,  R_JA,   A_JA,   A_T0);
            7'd51: u = mk(OP_MULC, R_T0,   A_P2X6, A_DX);
            7'd52: u = mk(OP_ADD,  R_JA,   A_JA,   A_T0);
            7'd53: u = mk(OP_MULC, R_JB,   A_G,    A_DXY);
            7'd54: u = mk(OP_MULC, R_T0,   A_P1X2, A_DX);
            7'd55: u = mk(OP_ADD,  R_JB,   A_JB,   A_T0);
            7'd56: u = mk(OP_MULC, R_T0,   A_P2X2, A_DY);
            7'd57: u = mk(OP_ADD,  R_JB,   A_JB,   A_T0);
            7'd58: u = mk(OP_MULC, R_T0,   A_G,    A_DYY);
            7'd59: u = mk(OP_ADD,  R_JD,   A_DV,   A_T0);
            7'd60: u = mk(OP_MULC, R_T0,   A_P2X2, A_DX);
            7'd61: u = mk(OP_ADD,  R_JD,   A_JD,   A_T0);
            7'd62: u = mk(OP_MULC, R_T0,   A_P1X6, A_DY);
            7'd63: u = mk(OP_ADD,  R_JD,   A_JD,   A_T0);
            7'd64: u = mk(OP_MULI, R_T0,   A_JA,   A_JD);
            7'd65: u = mk(OP_MULI, R_T1,   A_JB,   A_JB);
            7'd66: u = mk(OP_SUB,  R_DET,  A_T0,   A_T1);
            7'd67: u = mk(OP_BDET, R_DET,  A_DET,  S_ZERO);
            7'd68: u = mk(OP_MULI, R_T0,   A_JD,   A_FX);
            7'd69: u = mk(OP_MULI, R_T1,   A_JB,   A_FY);
            7'd70: u = mk(OP_SUB,  R_NX,   A_T0,   A_T1);
            7'd71: u = mk(OP_MULI, R_T0,   A_JA,   A_FY);
            7'd72: u = mk(OP_MULI, R_T1,   A_JB,   A_FX);
            7'd73: u = mk(OP_SUB,  R_NY,   A_T0,   A_T1);
            7'd74: u = mk(OP_DIV,  R_T0,   A_NX,   A_DET);
            7'd75: u = mk(OP_SUB,  R_PX,   A_PX,   A_T0);
            7'd76: u = mk(OP_DIV,  R_T0,   A_NY,   A_DET);
            7'd77: u = mk(OP_SUB,  R_PY,   A_PY,   A_T0);
            default: u = mk(OP_NEXT, R_T0, S_ZERO, S_ZERO);
        endcase
        return u;
    endfunction

endpackage

[rtl/ltn_mul.sv]
// multi-cycle signed 64x64 multiplier: four 32x32 partial products,
// then floor shift by a selected fraction width and saturation; uses ltn_pkg
`timescale 1ns / 1ps

module ltn_mul import ltn_pkg::*; #(
    parameter int COORD_FRAC_BITS = COORD_FRAC_DEFAULT,
    parameter int COEF_FRAC_BITS  = COEF_FRAC_DEFAULT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_a,
    input  logic [63:0] i_b,
    input  t_shsel      i_shift,
    output logic        o_done,
    output logic [63:0] o_result
);

    localparam int IF_BITS = 2 * COORD_FRAC_BITS;

    typedef enum logic [1:0] {M_IDLE, M_PP, M_NEG, M_SAT} t_mstate;

    t_mstate      r_state;
    logic [63:0]  r_ua, r_ub;
    logic         r_neg;
    logic [1:0]   r_cnt;
    logic [127:0] r_acc;
    t_shsel       r_sh;
    logic         r_done;
    logic [63:0]  r_result;

    logic [31:0]  pa, pb;
    logic [63:0]  prod;
    logic [127:0] prod_sh;
    logic [127:0] shifted;
    logic [63:0]  sat;

    always_comb begin
        pa   = r_cnt[1] ? r_ua[63:32] : r_ua[31:0];
        pb   = r_cnt[0] ? r_ub[63:32] : r_ub[31:0];
        prod = {32'b0, pa} * {32'b0, pb};
        unique case (r_cnt)
            2'd0:        prod_sh = {64'b0, prod};
            2'd1, 2'd2:  prod_sh = {32'b0, prod, 32'b0};
            default:     prod_sh = {prod, 64'b0};
        endcase
    end

    always_comb begin
        unique case (r_sh)
            SH_COORD: shifted = 128'($signed(r_acc) >>> IF_BITS);
            SH_COEF:  shifted = 128'($signed(r_acc) >>> COEF_FRAC_BITS);
            default:  shifted = r_acc;
        endcase
        if (shifted[127:63] == '0 || shifted[127:63] == '1) begin
            sat = shifted[63:0];
        end else if (shifted[127]) begin
            sat = 64'h8000_0000_0000_0000;
        end else begin
            sat = 64'h7FFF_FFFF_FFFF_FFFF;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= M_IDLE;
            r_done  <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                M_IDLE: begin
                    if (i_start) begin
                        r_ua    <= i_a[63] ? (64'd0 - i_a) : i_a;
                        r_ub    <= i_b[63] ? (64'd0 - i_b) : i_b;
                        r_neg   <= i_a[63] ^ i_b[63];
                        r_sh    <= i_shift;
                        r_acc   <= '0;
                        r_cnt   <= '0;
                        r_state <= M_PP;
                    end
                end
                M_PP: begin
                    r_acc <= r_acc + prod_sh;
                    r_cnt <= r_cnt + 2'd1;
                    if (r_cnt == 2'd3) begin
                        r_state <= M_NEG;
                    end
                end
                M_NEG: begin
                    if (r_neg) begin
                        r_acc <= 128'd0 - r_acc;
                    end
                    r_state <= M_SAT;
                end
                M_SAT: begin
                    r_result <= sat;
                    r_done   <= 1'b1;
                    r_state  <= M_IDLE;
                end
                default: r_state <= M_IDLE;
            endcase
        end
    end

    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

[rtl/ltn_div.sv]
// bit-serial signed divider: (n * 2^(2*coord frac)) / d, truncated toward
// zero and saturated to 64 bits, one quotient bit a cycle; uses ltn_pkg
`timescale 1ns / 1ps

module ltn_div import ltn_pkg::*; #(
    parameter int COORD_FRAC_BITS = COORD_FRAC_DEFAULT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_n,
    input  logic [63:0] i_d,
    output logic        o_done,
    output logic [63:0] o_result
);

    localparam int IF_BITS = 2 * COORD_FRAC_BITS;

    typedef enum logic [1:0] {D_IDLE, D_RUN, D_FIN} t_dstate;

    t_dstate      r_state;
    logic [127:0] r_dvd;
    logic [127:0] r_q;
    logic [63:0]  r_ud;
    logic [63:0]  r_rem;
    logic         r_neg;
    logic [6:0]   r_cnt;
    logic         r_done;
    logic [63:0]  r_result;

    logic [63:0]  un;
    logic [64:0]  trial;
    logic [64:0]  diff;
    logic         ge;

    always_comb begin
        un    = i_n[63] ? (64'd0 - i_n) : i_n;
        trial = {r_rem, r_dvd[127]};
        diff  = trial - {1'b0, r_ud};
        ge    = (trial >= {1'b0, r_ud});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= D_IDLE;
            r_done  <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                D_IDLE: begin
                    if (i_start) begin
                        r_dvd   <= {64'b0, un} << IF_BITS;
                        r_ud    <= i_d[63] ? (64'd0 - i_d) : i_d;
                        r_neg   <= i_n[63] ^ i_d[63];
                        r_rem   <= '0;
                        r_q     <= '0;
                        r_cnt   <= '0;
                        r_state <= D_RUN;
                    end
                end
                D_RUN: begin
                    r_rem <= ge ? diff[63:0] : trial[63:0];
                    r_q   <= {r_q[126:0], ge};
                    r_dvd <= {r_dvd[126:0], 1'b0};
                    r_cnt <= r_cnt + 7'd1;
                    if (r_cnt == 7'd127) begin
                        r_state <= D_FIN;
                    end
                end
                D_FIN: begin
                    if (r_neg) begin
                        if (r_q[127:64] != '0 || r_q[63]) begin
                            r_result <= 64'h8000_0000_0000_0000;
                        end else begin
                            r_result <= 64'd0 - r_q[63:0];
                        end
                    end else begin
                        if (r_q[127:64] != '0 || r_q[63]) begin
                            r_result <= 64'h7FFF_FFFF_FFFF_FFFF;
                        end else begin
                            r_result <= r_q[63:0];
                        end
                    end
                    r_done  <= 1'b1;
                    r_state <= D_IDLE;
                end
                default: r_state <= D_IDLE;
            endcase
        end
    end

    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

[rtl/lens_undistort_newton.sv]
// top level: micro-coded newton sequencer over a register file, one shared
// multiplier (ltn_mul) and one serial divider (ltn_div); uses ltn_pkg
`timescale 1ns / 1ps

// usage
//   configuration: i_cfg_we / i_cfg_idx / i_cfg_data write one register per
//   cycle (0 center, 1..3 radial, 4..5 tangential, 6 error limit, 7 step
//   limit); write only while busy is low
//   input: a point is taken at the clock edge where start is high and busy
//   is low; busy then stays high until the result has been shown
//   output: o_valid is high for exactly one cycle with the undistorted point,
//   steps used and status; the receiver cannot stall, so no result waits
//   sequencing: each micro-op passes through a fetch and an execute state; a
//   multiply or divide adds a wait state until its unit reports done. each
//   newton step issues two divides and 33 multiplies, which dominate its run
//   time; the block takes no new item until the current one is done
//   reset: synchronous active low; configuration registers return to their
//   reset values (step limit 20, all others zero) and the sequencer goes idle

module lens_undistort_newton import ltn_pkg::*; #(
    parameter int COORD_FRAC_BITS = COORD_FRAC_DEFAULT,
    parameter int COEF_FRAC_BITS  = COEF_FRAC_DEFAULT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [63:0] i_cfg_data,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] i_distorted_x,
    input  logic [31:0] i_distorted_y,
    output logic        o_valid,
    output logic [31:0] o_undistorted_x,
    output logic [31:0] o_undistorted_y,
    output logic [7:0]  o_steps_used,
    output logic [1:0]  o_status
);

    localparam int IF_BITS = 2 * COORD_FRAC_BITS;

    typedef enum logic [2:0] {S_IDLE, S_FETCH, S_EXEC, S_WAIT} t_state;

    // configuration
    logic [63:0] r_center, r_kap1, r_kap2, r_kap3, r_rho1, r_rho2;
    logic [31:0] r_err_lim;
    logic [7:0]  r_step_lim;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center   <= '0;
            r_kap1     <= '0;
            r_kap2     <= '0;
            r_kap3     <= '0;
            r_rho1     <= '0;
            r_rho2     <= '0;
            r_err_lim  <= '0;
            r_step_lim <= STEP_LIMIT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_CENTER:    r_center   <= i_cfg_data;
                CFG_KAPPA1:    r_kap1     <= i_cfg_data;
                CFG_KAPPA2:    r_kap2     <= i_cfg_data;
                CFG_KAPPA3:    r_kap3     <= i_cfg_data;
                CFG_RHO1:      r_rho1     <= i_cfg_data;
                CFG_RHO2:      r_rho2     <= i_cfg_data;
                CFG_ERR_LIMIT: r_err_lim  <= i_cfg_data[31:0];
                CFG_STEP_LIM:  r_step_lim <= i_cfg_data[7:0];
                default:       r_step_lim <= r_step_lim;
            endcase
        end
    end

    function automatic logic [63:0] widen(input logic [31:0] v);
        return {{32{v[31]}}, v} << COORD_FRAC_BITS;
    endfunction

    function automatic logic [63:0] sat_addsub(input logic [63:0] a, input logic [63:0] b,
                                               input logic sub);
        logic [64:0] s;
        s = sub ? ({a[63], a} - {b[63], b}) : ({a[63], a} + {b[63], b});
        if (s[64] != s[63]) begin
            return s[64] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
        end
        return s[63:0];
    endfunction

    function automatic logic [31:0] to_out(input logic [63:0] v);
        logic [63:0] f;
        f = 64'($signed(v) >>> COORD_FRAC_BITS);
        if (f[63:31] == '0 || f[63:31] == '1) begin
            return f[31:0];
        end
        return f[63] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    endfunction

    // sequencer state
    t_state          r_state;
    logic [PC_W-1:0] r_pc;
    logic [7:0]      r_steps;
    logic [31:0]     r_xd, r_yd;
    logic [63:0]     r_opa, r_opb;
    logic [63:0]     r_px, r_py;
    logic            r_valid;
    logic [31:0]     r_out_x, r_out_y;
    logic [7:0]      r_out_steps;
    logic [1:0]      r_out_status;
    logic            r_mul_go, r_div_go;
    t_shsel          r_mul_sh;

    logic [63:0] r_rf [32];

    t_uop        uop;
    logic [63:0] spec_a, spec_b;
    logic        rd_en;
    logic        wr_en;
    logic [63:0] wr_data;
    logic [63:0] alu_res;
    logic        mul_done, div_done;
    logic [63:0] mul_res, div_res;

    assign uop = uop_rom(r_pc);

    function automatic logic [63:0] special(
        input logic [5:0] adr, input logic [63:0] center, input logic [63:0] k1,
        input logic [63:0] k2, input logic [63:0] k3, input logic [63:0] p1,
        input logic [63:0] p2, input logic [31:0] xd, input logic [31:0] yd);
        logic [63:0] v;
        unique case (adr)
            S_CX:    v = widen(center[31:0]);
            S_CY:    v = widen(center[63:32]);
            S_K1:    v = k1;
            S_K2:    v = k2;
            S_K3:    v = k3;
            S_P1:    v = p1;
            S_P2:    v = p2;
            S_ONE:   v = 64'd1 << IF_BITS;
            S_C2:    v = 64'd2;
            S_C4:    v = 64'd4;
            S_C6:    v = 64'd6;
            S_XD:    v = widen(xd);
            S_YD:    v = widen(yd);
            default: v = '0;
        endcase
        return v;
    endfunction

    always_comb begin
        spec_a  = special(uop.src_a, r_center, r_kap1, r_kap2, r_kap3, r_rho1, r_rho2,
                          r_xd, r_yd);
        spec_b  = special(uop.src_b, r_center, r_kap1, r_kap2, r_kap3, r_rho1, r_rho2,
                          r_xd, r_yd);
        alu_res = sat_addsub(r_opa, r_opb, uop.kind == OP_SUB);
        rd_en   = (r_state == S_FETCH);
        wr_en   = 1'b0;
        wr_data = alu_res;
        if (r_state == S_EXEC && (uop.kind == OP_ADD || uop.kind == OP_SUB)) begin
            wr_en = 1'b1;
        end else if (r_state == S_WAIT && (mul_done || div_done)) begin
            wr_en   = 1'b1;
            wr_data = div_done ? div_res : mul_res;
        end
    end

    // register file: one write port, two registered read ports
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_rf[uop.dst] <= wr_data;
        end
        if (rd_en) begin
            r_opa <= uop.src_a[5] ? spec_a : r_rf[uop.src_a[4:0]];
            r_opb <= uop.src_b[5] ? spec_b : r_rf[uop.src_b[4:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_valid  <= 1'b0;
            r_mul_go <= 1'b0;
            r_div_go <= 1'b0;
            r_pc     <= '0;
            r_steps  <= '0;
        end else begin
            r_valid  <= 1'b0;
            r_mul_go <= 1'b0;
            r_div_go <= 1'b0;
            if (wr_en && uop.dst == R_PX) begin
                r_px <= wr_data;
            end
            if (wr_en && uop.dst == R_PY) begin
                r_py <= wr_data;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_xd    <= i_distorted_x;
                        r_yd    <= i_distorted_y;
                        r_pc    <= '0;
                        r_steps <= '0;
                        r_state <= S_FETCH;
                    end
                end
                S_FETCH: begin
                    // iteration limit is checked before every newton step
                    if (r_pc == LOOP_PC && r_steps >= r_step_lim) begin
                        r_valid      <= 1'b1;
                        r_out_x      <= to_out(r_px);
                        r_out_y      <= to_out(r_py);
                        r_out_steps  <= r_steps;
                        r_out_status <= ST_LIMIT;
                        r_state      <= S_IDLE;
                    end else begin
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    unique case (uop.kind)
                        OP_ADD, OP_SUB: begin
                            r_pc    <= r_pc + 7'd1;
                            r_state <= S_FETCH;
                        end
                        OP_MUL0, OP_MULI, OP_MULC: begin
                            r_mul_go <= 1'b1;
                            r_mul_sh <= (uop.kind == OP_MUL0) ? SH_NONE :
                                        (uop.kind == OP_MULI) ? SH_COORD : SH_COEF;
                            r_state  <= S_WAIT;
                        end
                        OP_DIV: begin
                            r_div_go <= 1'b1;
                            r_state  <= S_WAIT;
                        end
                        OP_BERR: begin
                            if ($signed(r_opa) < $signed({32'b0, r_err_lim})) begin
                                r_valid      <= 1'b1;
                                r_out_x      <= to_out(r_px);
                                r_out_y      <= to_out(r_py);
                                r_out_steps  <= r_steps;
                                r_out_status <= ST_CONVERGED;
                                r_state      <= S_IDLE;
                            end else begin
                                r_pc    <= r_pc + 7'd1;
                                r_state <= S_FETCH;
                            end
                        end
                        OP_BDET: begin
                            if (r_opa == '0) begin
                                r_valid      <= 1'b1;
                                r_out_x      <= to_out(r_px);
                                r_out_y      <= to_out(r_py);
                                r_out_steps  <= r_steps;
                                r_out_status <= ST_SINGULAR;
                                r_state      <= S_IDLE;
                            end else begin
                                r_pc    <= r_pc + 7'd1;
                                r_state <= S_FETCH;
                            end
                        end
                        default: begin
                            // end of a newton step
                            r_steps <= r_steps + 8'd1;
                            r_pc    <= LOOP_PC;
                            r_state <= S_FETCH;
                        end
                    endcase
                end
                S_WAIT: begin
                    if (mul_done || div_done) begin
                        r_pc    <= r_pc + 7'd1;
                        r_state <= S_FETCH;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    ltn_mul #(
        .COORD_FRAC_BITS (COORD_FRAC_BITS),
        .COEF_FRAC_BITS  (COEF_FRAC_BITS)
    ) u_mul (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (r_mul_go),
        .i_a      (r_opa),
        .i_b      (r_opb),
        .i_shift  (r_mul_sh),
        .o_done   (mul_done),
        .o_result (mul_res)
    );

    ltn_div #(
        .COORD_FRAC_BITS (COORD_FRAC_BITS)
    ) u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (r_div_go),
        .i_n      (r_opa),
        .i_d      (r_opb),
        .o_done   (div_done),
        .o_result (div_res)
    );

    assign busy            = (r_state != S_IDLE);
    assign o_valid         = r_valid;
    assign o_undistorted_x = r_out_x;
    assign o_undistorted_y = r_out_y;
    assign o_steps_used    = r_out_steps;
    assign o_status        = r_out_status;

endmodule
